// ===== src/wsfd_pkg.sv =====
package wsfd_pkg;

    // Parser phase; the unused codes fall back to expecting the first header byte.
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    localparam logic [7:0] FIN_BIT      = 8'h80;
    localparam logic [7:0] OPCODE_MASK  = 8'h0F;
    localparam logic [7:0] LEN_MASK     = 8'h7F;
    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [2:0] EXT16_BYTES  = 3'd2;

    // One classified beat waiting between the parser and the output stage.
    typedef struct packed {
        logic        is_header;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic        was_masked;
        logic [63:0] payload_length;
        logic [7:0]  raw_byte;
        logic [7:0]  key_byte;
        logic        frame_end;
    } t_qent;

endpackage

// ===== src/wsfd_byte_if.sv =====
interface wsfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/wsfd_res_if.sv =====
interface wsfd_res_if;
    logic        valid;
    logic        ready;
    logic        is_header;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        was_masked;
    logic [63:0] payload_length;
    logic [7:0]  data_byte;
    logic        frame_end;

    modport source (
        output valid, output is_header, output fin_flag, output frame_opcode,
        output was_masked, output payload_length, output data_byte, output frame_end,
        input ready
    );
    modport sink (
        input valid, input is_header, input fin_flag, input frame_opcode,
        input was_masked, input payload_length, input data_byte, input frame_end,
        output ready
    );
endinterface

// ===== src/wsfd_front.sv =====
module wsfd_front
    import wsfd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  logic   i_space,
    input  logic [7:0] i_byte,
    output logic   o_ready,
    output logic   o_push,
    output t_qent  o_ent
);

    t_phase      r_phase, n_phase;
    logic        r_fin, n_fin;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;
    logic [63:0] r_len, n_len;
    logic [2:0]  r_cnt, n_cnt;
    logic [31:0] r_key, n_key;
    logic [63:0] r_rem, n_rem;
    logic [1:0]  r_kidx, n_kidx;

    logic        acc;
    logic [2:0]  cnt_inc;
    logic        after_len;
    logic        finish;
    logic [31:0] key_sh;

    assign o_ready = i_space;
    assign acc     = i_valid & i_space;
    assign cnt_inc = r_cnt + 3'd1;
    // Key byte for this payload position: first key byte sits in the top bits.
    assign key_sh  = r_key >> {~r_kidx, 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_cnt   <= 3'd0;
            r_kidx  <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_kidx  <= n_kidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin    <= n_fin;
        r_opcode <= n_opcode;
        r_masked <= n_masked;
        r_len    <= n_len;
        r_key    <= n_key;
        r_rem    <= n_rem;
    end

    always_comb begin
        n_phase   = r_phase;
        n_fin     = r_fin;
        n_opcode  = r_opcode;
        n_masked  = r_masked;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_key     = r_key;
        n_rem     = r_rem;
        n_kidx    = r_kidx;
        after_len = 1'b0;
        finish    = 1'b0;
        o_push    = 1'b0;
        o_ent     = '0;
        if (acc) begin
            case (r_phase)
                PH_SECOND: begin
                    n_masked = i_byte[7];
                    n_cnt    = 3'd0;
                    if (i_byte[6:0] == LEN_CODE_16) begin
                        n_len   = 64'd0;
                        n_phase = PH_EXT16;
                    end else if (i_byte[6:0] == LEN_CODE_64) begin
                        n_len   = 64'd0;
                        n_phase = PH_EXT64;
                    end else begin
                        n_len     = 64'(i_byte & LEN_MASK);
                        after_len = 1'b1;
                    end
                end
                PH_EXT16: begin
                    n_len = {r_len[55:0], i_byte};
                    n_cnt = cnt_inc;
                    if (cnt_inc >= EXT16_BYTES || cnt_inc == 3'd0) begin
                        after_len = 1'b1;
                    end
                end
                PH_EXT64: begin
                    n_len = {r_len[55:0], i_byte};
                    n_cnt = cnt_inc;
                    // Counter wraps to zero after the eighth byte.
                    if (cnt_inc == 3'd0) begin
                        after_len = 1'b1;
                    end
                end
                PH_KEY: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = cnt_inc;
                    if (cnt_inc[2]) begin
                        finish = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_kidx = r_kidx + 2'd1;
                    if (r_rem != 64'd0) begin
                        n_rem = r_rem - 64'd1;
                    end
                    if (n_rem == 64'd0) begin
                        n_phase = PH_FIRST;
                    end
                    o_push             = 1'b1;
                    o_ent.is_header    = 1'b0;
                    o_ent.fin_flag     = r_fin;
                    o_ent.frame_opcode = r_opcode;
                    o_ent.was_masked   = r_masked;
                    o_ent.payload_length = r_len;
                    o_ent.raw_byte     = i_byte;
                    o_ent.key_byte     = r_masked ? key_sh[7:0] : 8'd0;
                    o_ent.frame_end    = (n_rem == 64'd0);
                end
                default: begin
                    n_fin    = (i_byte & FIN_BIT) != 8'd0;
                    n_opcode = 4'(i_byte & OPCODE_MASK);
                    n_masked = 1'b0;
                    n_len    = 64'd0;
                    n_cnt    = 3'd0;
                    n_key    = 32'd0;
                    n_rem    = 64'd0;
                    n_kidx   = 2'd0;
                    n_phase  = PH_SECOND;
                end
            endcase
            if (after_len) begin
                n_cnt = 3'd0;
                if (n_masked) begin
                    n_key   = 32'd0;
                    n_phase = PH_KEY;
                end else begin
                    finish = 1'b1;
                end
            end
            if (finish) begin
                n_rem   = n_len;
                n_kidx  = 2'd0;
                n_cnt   = 3'd0;
                n_phase = (n_len == 64'd0) ? PH_FIRST : PH_PAYLOAD;
                o_push             = 1'b1;
                o_ent.is_header    = 1'b1;
                o_ent.fin_flag     = r_fin;
                o_ent.frame_opcode = r_opcode;
                o_ent.was_masked   = n_masked;
                o_ent.payload_length = n_len;
                o_ent.raw_byte     = 8'd0;
                o_ent.key_byte     = 8'd0;
                o_ent.frame_end    = (n_len == 64'd0);
            end
        end
    end

    // The key phase is only ever entered for a masked frame.
    a_key_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_KEY |-> r_masked)
        else $error("key phase without mask flag");

    // The 16-bit extended length never counts past its two bytes.
    a_ext16_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_EXT16 |-> r_cnt < EXT16_BYTES)
        else $error("16-bit length counter overran");

endmodule

// ===== src/wsfd_fifo.sv =====
module wsfd_fifo
    import wsfd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_data,
    output logic  o_space,
    input  logic  i_pop,
    output logic  o_valid,
    output t_qent o_data
);

    t_qent      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & o_space;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // The parser is held off while full, so nothing is ever pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != 2'd2)
        else $error("push into full queue");

endmodule

// ===== src/wsfd_back.sv =====
module wsfd_back
    import wsfd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_qent i_ent,
    output logic  o_pop,
    wsfd_res_if.source o_res
);

    logic        r_valid;
    logic        r_is_header;
    logic        r_fin;
    logic [3:0]  r_opcode;
    logic        r_masked;
    logic [63:0] r_len;
    logic [7:0]  r_data;
    logic        r_end;

    assign o_pop = i_valid & (!r_valid | o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_res.ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_is_header <= i_ent.is_header;
            r_fin       <= i_ent.fin_flag;
            r_opcode    <= i_ent.frame_opcode;
            r_masked    <= i_ent.was_masked;
            r_len       <= i_ent.payload_length;
            r_data      <= i_ent.raw_byte ^ i_ent.key_byte;
            r_end       <= i_ent.frame_end;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.is_header      = r_is_header;
    assign o_res.fin_flag       = r_fin;
    assign o_res.frame_opcode   = r_opcode;
    assign o_res.was_masked     = r_masked;
    assign o_res.payload_length = r_len;
    assign o_res.data_byte      = r_data;
    assign o_res.frame_end      = r_end;

    // A header beat always carries a zero data byte.
    a_hdr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_is_header |-> r_data == 8'd0)
        else $error("header beat with non-zero data");

endmodule

// ===== src/websocket_frame_decoder.sv =====
// A byte that completes a header or carries payload is written to the queue at the edge
// that accepts it and moves into the output register once that register is free; its
// result beat is offered from there. Throughput: one byte per cycle while the queue has
// space, set by the single-byte parser step; header bytes that complete nothing give no
// beat. Reset is synchronous and active low: it returns the parser to the first header
// byte, empties the queue and drops the output beat.
module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    wsfd_byte_if.sink   i_rx,
    wsfd_res_if.source  o_res
);

    // The front parser walks the RFC 6455 header one byte at a time and classifies each
    // byte. Bytes that finish a header or carry payload become queue entries; the
    // entry already holds the selected masking key byte, so the back end only XORs.
    logic  push;
    logic  space;
    t_qent ent_in;
    logic  q_valid;
    logic  pop;
    t_qent ent_out;

    wsfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .i_space (space),
        .i_byte  (i_rx.rx_byte),
        .o_ready (i_rx.ready),
        .o_push  (push),
        .o_ent   (ent_in)
    );

    // A two-entry queue lets the parser keep taking bytes while a finished beat
    // waits at the output.
    wsfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (ent_in),
        .o_space (space),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (ent_out)
    );

    // The back end unmasks the payload byte and holds the result beat in a register.
    wsfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_ent   (ent_out),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
